// File: sv/fplq_pkg.sv
// Shared types and constants for the five-level priority queue.
`default_nettype none

package fplq_pkg;

	localparam int DATA_W = 32;
	localparam int LVL_W  = 3;
	localparam int OCC_W  = 5;
	localparam int CAP_W  = 5;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ   = 2'd0,
		KIND_FRONT = 2'd1,
		KIND_HIGH  = 2'd2,
		KIND_PEEK  = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_BADLV = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic              load_en;
		logic              remove;
		logic              front;
		logic [LVL_W-1:0]  target;
		logic [DATA_W-1:0] wdata;
		logic [LVL_W-1:0]  wlevel;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/fplq_if.sv
// Request and response channel interfaces of the priority queue.
`default_nettype none

interface fplq_cmd_if import fplq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] value;
	logic [LVL_W-1:0]         level;

	modport source (output valid, kind, value, level, input ready);
	modport sink   (input valid, kind, value, level, output ready);
endinterface

interface fplq_rsp_if import fplq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	logic [STAT_W-1:0]        status;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, data, status, occupancy, input ready);
	modport sink   (input valid, data, status, occupancy, output ready);
endinterface

`default_nettype wire

// File: sv/five_level_priority_queue.sv
// Five-level priority queue: requests in on cmd, one response each on rsp.
// cmd carries kind (enqueue, dequeue front, dequeue highest, peek), value and
// level; rsp returns data, status and occupancy after the request.
// Entries sit in a chain of DEPTH cells, oldest in cell 0. A request is taken
// in one cycle and executed the next: every cell compares its level with the
// highest level present (any occupied cell matches for a front dequeue), a
// hit flag ripples down the chain to pick the oldest match, and on a dequeue
// all cells at or behind it shift left by one in the same cycle. The response
// is valid in the cycle after the execute cycle; no new request is accepted
// until the previous one has executed on the single cell chain.
// The response sits in an output register; a new request is accepted while it
// waits only if rsp.ready is high in that cycle, so a stalled receiver holds
// the response and blocks cmd without losing anything.
// Reset empties the queue and clears capacity_limit (full depth); no clearing
// pass is needed, cell contents beyond the occupancy are never used.
// capacity_limit is at APB address 0; write it only while idle.
`default_nettype none

module five_level_priority_queue import fplq_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int LEVELS = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	fplq_cmd_if.sink         cmd,
	fplq_rsp_if.source       rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	state_t            state_q;
	logic [KIND_W-1:0] kind_q;
	logic [DATA_W-1:0] value_q;
	logic [LVL_W-1:0]  level_q;
	logic [CW-1:0]     total_q;
	logic [CAP_W-1:0]  cap_q;

	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_data_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [OCC_W-1:0]  rsp_occ_q;

	logic              exec;
	logic              nonempty;
	logic              full;
	logic              lvl_ok;
	logic              enq_ok;
	logic              deq;
	logic [LW-1:0]     cap_x;
	logic [LW-1:0]     limit;
	logic [CW-1:0]     total_nx;
	logic [LVL_W-1:0]  highest;
	logic [LVL_W-1:0]  dec_level;
	logic [STAT_W-1:0] status_nx;
	logic [DATA_W-1:0] data_nx;
	cell_ctl_t         ctl;

	logic              hit  [DEPTH+1];
	logic [DATA_W-1:0] word [DEPTH+1];
	logic [DATA_W-1:0] cdata [DEPTH];
	logic [LVL_W-1:0]  clvl  [DEPTH];

	fplq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap_q   (cap_q)
	);

	assign cmd.ready = (state_q == S_IDLE) & (~rsp_valid_q | rsp.ready);
	assign exec      = (state_q == S_EXEC);

	// decode of the latched request
	assign cap_x    = LW'(cap_q);
	assign limit    = ((cap_q == '0) || (cap_x > LW'(DEPTH))) ? LW'(DEPTH) : cap_x;
	assign nonempty = (total_q != '0);
	assign full     = (LW'(total_q) >= limit);
	assign lvl_ok   = ({1'b0, level_q} < (LVL_W + 1)'(LEVELS));
	assign enq_ok   = (kind_q == KIND_ENQ) & ~full & lvl_ok;
	assign deq      = ((kind_q == KIND_FRONT) | (kind_q == KIND_HIGH)) & nonempty;

	assign ctl.load_en = exec & enq_ok;
	assign ctl.remove  = exec & deq;
	assign ctl.front   = (kind_q == KIND_FRONT);
	assign ctl.target  = highest;
	assign ctl.wdata   = value_q;
	assign ctl.wlevel  = level_q;

	assign dec_level = ctl.front ? clvl[0] : highest;

	fplq_lvl #(
		.DEPTH  (DEPTH),
		.LEVELS (LEVELS)
	) u_lvl (
		.clk       (clk),
		.arst_n    (arst_n),
		.inc       (ctl.load_en),
		.inc_level (level_q),
		.dec       (ctl.remove),
		.dec_level (dec_level),
		.highest   (highest)
	);

	assign hit[0]  = 1'b0;
	assign word[0] = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] nd;
		logic [LVL_W-1:0]  nl;

		if (g == DEPTH - 1) begin : g_last
			assign nd = cdata[g];
			assign nl = clvl[g];
		end else begin : g_mid
			assign nd = cdata[g+1];
			assign nl = clvl[g+1];
		end

		fplq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (CW'(g) < total_q),
			.load      (CW'(g) == total_q),
			.hit_in    (hit[g]),
			.word_in   (word[g]),
			.nxt_data  (nd),
			.nxt_level (nl),
			.hit_out   (hit[g+1]),
			.word_out  (word[g+1]),
			.data_q    (cdata[g]),
			.level_q   (clvl[g])
		);
	end

	always_comb begin
		total_nx  = total_q;
		status_nx = STAT_OK;
		data_nx   = '0;
		unique case (kind_q)
			KIND_ENQ: begin
				if (full) begin
					status_nx = STAT_FULL;
				end else if (!lvl_ok) begin
					status_nx = STAT_BADLV;
				end else begin
					total_nx = total_q + CW'(1);
				end
			end
			KIND_FRONT, KIND_HIGH, KIND_PEEK: begin
				if (!nonempty) begin
					status_nx = STAT_EMPTY;
				end else begin
					data_nx = word[DEPTH];
					if (kind_q != KIND_PEEK) total_nx = total_q - CW'(1);
				end
			end
			default: begin
				status_nx = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rsp.ready) rsp_valid_q <= 1'b0;
					if (cmd.valid & cmd.ready) state_q <= S_EXEC;
				end
				S_EXEC: begin
					total_q     <= total_nx;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid & cmd.ready) begin
			kind_q  <= cmd.kind;
			value_q <= cmd.value;
			level_q <= cmd.level;
		end
		if (exec) begin
			rsp_data_q   <= data_nx;
			rsp_status_q <= status_nx;
			rsp_occ_q    <= OCC_W'(total_nx);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data      = rsp_data_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.occupancy = rsp_occ_q;

endmodule

`default_nettype wire

// File: sv/fplq_cell.sv
// One storage cell of the queue chain: holds an entry, shifts from its right neighbor.
`default_nettype none

module fplq_cell import fplq_pkg::*; (
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic              occ,
	input  wire logic              load,
	input  wire logic              hit_in,
	input  wire logic [DATA_W-1:0] word_in,
	input  wire logic [DATA_W-1:0] nxt_data,
	input  wire logic [LVL_W-1:0]  nxt_level,
	output logic                   hit_out,
	output logic [DATA_W-1:0]      word_out,
	output logic [DATA_W-1:0]      data_q,
	output logic [LVL_W-1:0]       level_q
);

	logic match;

	assign match    = occ & (ctl.front | (level_q == ctl.target));
	assign hit_out  = hit_in | match;
	// first matching cell drops its word onto the chain
	assign word_out = (match & ~hit_in) ? data_q : word_in;

	always_ff @(posedge clk) begin
		if (ctl.load_en & load) begin
			data_q  <= ctl.wdata;
			level_q <= ctl.wlevel;
		end else if (ctl.remove & hit_out) begin
			data_q  <= nxt_data;
			level_q <= nxt_level;
		end
	end

endmodule

`default_nettype wire

// File: sv/fplq_lvl.sv
// Per-level entry counters and highest-present-level pick.
`default_nettype none

module fplq_lvl import fplq_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int LEVELS = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             inc,
	input  wire logic [LVL_W-1:0] inc_level,
	input  wire logic             dec,
	input  wire logic [LVL_W-1:0] dec_level,
	output logic [LVL_W-1:0]      highest
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [CW-1:0] cnt_q [LEVELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) cnt_q[i] <= '0;
		end else begin
			if (inc) cnt_q[inc_level[LIW-1:0]] <= cnt_q[inc_level[LIW-1:0]] + CW'(1);
			if (dec) cnt_q[dec_level[LIW-1:0]] <= cnt_q[dec_level[LIW-1:0]] - CW'(1);
		end
	end

	always_comb begin
		highest = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (cnt_q[i] != '0) highest = LVL_W'(i);
		end
	end

endmodule

`default_nettype wire

// File: sv/fplq_regs.sv
// APB configuration register: capacity limit.
`default_nettype none

module fplq_regs import fplq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [CAP_W-1:0] cap_q
);

	localparam logic REG_CAP = 1'b0;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAP) ? {{(32-CAP_W){1'b0}}, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (psel & penable & pwrite & pready & (paddr[2] == REG_CAP)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: dv/five_level_priority_queue_test.sv
// Self-checking testbench for the five-level priority queue: random and directed requests.
`timescale 1ns / 100ps

module five_level_priority_queue_test import fplq_pkg::*; ();

	localparam int DEPTH           = 16;
	localparam int LEVELS          = 5;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_AT_RSP     = 700;
	localparam int HOLD_CYCLES     = 300;
	localparam int MAX_PRINTED     = 40;
	localparam logic [2:0] CAP_ADDR    = 3'd0;
	localparam logic [2:0] UNUSED_ADDR = 3'd4;

	typedef struct {
		kind_t                    kind;
		logic signed [DATA_W-1:0] value;
		logic [LVL_W-1:0]         level;
	} queue_cmd_t;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
	} queue_rsp_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	fplq_cmd_if cmd_ch ();
	fplq_rsp_if rsp_ch ();

	five_level_priority_queue #(
		.DEPTH  (DEPTH),
		.LEVELS (LEVELS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// shadow copy of the queue contents, oldest first
	logic signed [DATA_W-1:0] shadow_words [$];
	logic [LVL_W-1:0]         shadow_levels [$];
	logic [CAP_W-1:0]         shadow_cap = '0;

	queue_cmd_t pending_cmds [$];
	queue_rsp_t rsp_expected [$];

	int          err_count    = 0;
	int          cmds_sent    = 0;
	int          rsp_seen     = 0;
	int          reg_writes   = 0;
	int          cycle_count  = 0;
	int          status_hits [1<<STAT_W];
	int unsigned send_gap     = 0;
	int unsigned recv_gap     = 0;
	int unsigned hold_left    = 0;
	bit          send_idle_on = 1'b1;
	bit          recv_idle_on = 1'b1;
	int unsigned cap_plan [9] = '{16, 1, 31, 5, 0, 9, 17, 2, 0};

	task automatic flag_error(input string msg);
		if (err_count < MAX_PRINTED)
			$display("[%0t] ERROR: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic int unsigned draw_gap(input bit enabled);
		int unsigned pick;
		if (!enabled)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// applies one request to the shadow queue and returns the response it yields
	function automatic queue_rsp_t apply_queue_op(input queue_cmd_t c);
		queue_rsp_t  r;
		int unsigned lim;
		int          pos;
		r.data   = '0;
		r.status = STAT_OK;
		lim = (shadow_cap == 0 || shadow_cap > DEPTH) ? DEPTH : shadow_cap;
		if (c.kind == KIND_ENQ) begin
			if (shadow_words.size() >= lim) begin
				r.status = STAT_FULL;
			end else if (c.level >= LEVELS) begin
				r.status = STAT_BADLV;
			end else begin
				shadow_words.push_back(c.value);
				shadow_levels.push_back(c.level);
			end
		end else if (shadow_words.size() == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			pos = 0;
			// oldest entry of the highest level: strict compare keeps the first hit
			if (c.kind != KIND_FRONT) begin
				for (int i = 1; i < shadow_words.size(); i++)
					if (shadow_levels[i] > shadow_levels[pos])
						pos = i;
			end
			r.data = shadow_words[pos];
			if (c.kind != KIND_PEEK) begin
				shadow_words.delete(pos);
				shadow_levels.delete(pos);
			end
		end
		r.occupancy = OCC_W'(shadow_words.size());
		return r;
	endfunction

	task automatic push_cmd(input kind_t k, input logic signed [DATA_W-1:0] v,
			input logic [LVL_W-1:0] lv);
		queue_cmd_t c;
		c.kind  = k;
		c.value = v;
		c.level = lv;
		pending_cmds.push_back(c);
	endtask

	// returns at the edge where the last outstanding response was taken
	task automatic drain();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || rsp_expected.size() != 0);
	endtask

	// APB write, then read back capacity_limit
	task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == CAP_ADDR)
			shadow_cap = value[CAP_W-1:0];
		reg_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= CAP_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[CAP_W-1:0] !== shadow_cap)
			flag_error($sformatf("capacity_limit readback %0d, want %0d",
				prdata[CAP_W-1:0], shadow_cap));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				rsp_expected.push_back(apply_queue_op(pending_cmds.pop_front()));
				cmds_sent++;
				send_gap = draw_gap(send_idle_on);
			end
			if (!(cmd_ch.valid && !cmd_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					cmd_ch.valid <= 1'b1;
					cmd_ch.kind  <= pending_cmds[0].kind;
					cmd_ch.value <= pending_cmds[0].value;
					cmd_ch.level <= pending_cmds[0].level;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and ready generator
	always @(posedge clk) begin : rsp_monitor
		queue_rsp_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_seen++;
				status_hits[rsp_ch.status]++;
				if (rsp_expected.size() == 0) begin
					flag_error($sformatf("response with no request outstanding, data %0d",
						rsp_ch.data));
				end else begin
					want = rsp_expected.pop_front();
					if (rsp_ch.data !== want.data)
						flag_error($sformatf("rsp %0d data %0d, want %0d",
							rsp_seen, rsp_ch.data, want.data));
					if (rsp_ch.status !== want.status)
						flag_error($sformatf("rsp %0d status %0d, want %0d",
							rsp_seen, rsp_ch.status, want.status));
					if (rsp_ch.occupancy !== want.occupancy)
						flag_error($sformatf("rsp %0d occupancy %0d, want %0d",
							rsp_seen, rsp_ch.occupancy, want.occupancy));
				end
				// one long stall so the output register backs up into the request side
				if (rsp_seen == HOLD_AT_RSP)
					hold_left = HOLD_CYCLES;
				else
					recv_gap = draw_gap(recv_idle_on);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned              pick;
		int unsigned              enq_pct;
		kind_t                    k;
		logic [LVL_W-1:0]         lv;
		logic signed [DATA_W-1:0] val;

		cmd_ch.valid = 1'b0;
		cmd_ch.kind  = KIND_ENQ;
		cmd_ch.value = '0;
		cmd_ch.level = '0;
		rsp_ch.ready = 1'b0;
		foreach (status_hits[i])
			status_hits[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, bad levels, data extremes, priority order
		push_cmd(KIND_PEEK, 32'sd0, 3'd0);
		push_cmd(KIND_FRONT, 32'sd0, 3'd0);
		push_cmd(KIND_HIGH, 32'sd0, 3'd0);
		push_cmd(KIND_ENQ, 32'sd123, 3'd5);
		push_cmd(KIND_ENQ, 32'sd77, 3'd7);
		push_cmd(KIND_ENQ, 32'sh8000_0000, 3'd0);
		push_cmd(KIND_ENQ, 32'sh7fff_ffff, 3'd4);
		push_cmd(KIND_ENQ, -32'sd1, 3'd2);
		push_cmd(KIND_ENQ, 32'sd0, 3'd4);
		push_cmd(KIND_ENQ, 32'sd1, 3'd1);
		push_cmd(KIND_PEEK, 32'sd0, 3'd0);
		push_cmd(KIND_HIGH, 32'sd0, 3'd0);
		push_cmd(KIND_HIGH, 32'sd0, 3'd0);
		push_cmd(KIND_FRONT, 32'sd0, 3'd0);
		drain();

		// full wins over a bad level
		set_register(CAP_ADDR, 32'd2);
		push_cmd(KIND_ENQ, 32'sd9, 3'd7);
		push_cmd(KIND_ENQ, 32'sd5, 3'd3);
		push_cmd(KIND_FRONT, 32'sd0, 3'd0);
		push_cmd(KIND_ENQ, 32'sd6, 3'd6);
		push_cmd(KIND_ENQ, 32'sd42, 3'd3);
		drain();

		// shrink the limit below the current occupancy
		set_register(CAP_ADDR, 32'd0);
		for (int i = 0; i < 4; i++)
			push_cmd(KIND_ENQ, 32'(1000 + i), LVL_W'(i));
		drain();
		set_register(CAP_ADDR, 32'd3);
		set_register(UNUSED_ADDR, 32'd1);
		push_cmd(KIND_ENQ, 32'sd11, 3'd0);
		push_cmd(KIND_HIGH, 32'sd0, 3'd0);
		push_cmd(KIND_FRONT, 32'sd0, 3'd0);
		push_cmd(KIND_HIGH, 32'sd0, 3'd0);
		push_cmd(KIND_ENQ, 32'sd12, 3'd1);
		push_cmd(KIND_FRONT, 32'sd0, 3'd0);
		push_cmd(KIND_ENQ, 32'sd13, 3'd4);
		drain();

		foreach (cap_plan[ph]) begin
			set_register(CAP_ADDR, cap_plan[ph]);
			send_idle_on = (ph % 3) == 0;
			recv_idle_on = (ph % 3) != 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// alternate fill-heavy and drain-heavy stretches
				if (n % 30 == 0)
					enq_pct = ((n / 30) % 2 == 0) ? 75 : 30;
				pick = $urandom_range(0, 99);
				if (pick < enq_pct) begin
					k = KIND_ENQ;
				end else begin
					pick = $urandom_range(0, 99);
					k = (pick < 35) ? KIND_FRONT : (pick < 75) ? KIND_HIGH : KIND_PEEK;
				end
				pick = $urandom_range(0, 99);
				lv = (pick < 88) ? LVL_W'($urandom_range(0, LEVELS - 1))
				                 : LVL_W'($urandom_range(LEVELS, 7));
				pick = $urandom_range(0, 99);
				if (pick < 60)
					val = $urandom;
				else if (pick < 75)
					case ($urandom_range(0, 3))
						0: val = 32'sh8000_0000;
						1: val = 32'sh7fff_ffff;
						2: val = 32'sd0;
						default: val = -32'sd1;
					endcase
				else
					val = $signed(32'($urandom_range(0, 200))) - 32'sd100;
				push_cmd(k, val, lv);
			end
			drain();
		end

		repeat (4) @(posedge clk);
		$display("Checked %0d responses to %0d requests over %0d register writes",
			rsp_seen, cmds_sent, reg_writes);
		$display("Status mix: %0d ok, %0d full, %0d bad level, %0d empty",
			status_hits[STAT_OK], status_hits[STAT_FULL], status_hits[STAT_BADLV],
			status_hits[STAT_EMPTY]);
		if (err_count == 0 && rsp_expected.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
